// ===== sv/llsd_pkg.sv =====
package llsd_pkg;

  // Input actions.
  localparam logic [2:0] ACT_LOGIN   = 3'd0;
  localparam logic [2:0] ACT_LOGOUT  = 3'd1;
  localparam logic [2:0] ACT_STATUS  = 3'd2;
  localparam logic [2:0] ACT_REQUEST = 3'd3;
  localparam logic [2:0] ACT_TICK    = 3'd4;
  localparam logic [2:0] ACT_TAKE    = 3'd5;
  localparam logic [2:0] ACT_END     = 3'd6;

  // Result kinds.
  localparam logic [1:0] KIND_ASSIGNED = 2'd0;
  localparam logic [1:0] KIND_QUEUED   = 2'd1;
  localparam logic [1:0] KIND_TIMEOUT  = 2'd2;
  localparam logic [1:0] KIND_DROPPED  = 2'd3;

  localparam logic [3:0]  LOAD_MAX        = 4'd15;
  localparam logic [1:0]  STATUS_ONLINE   = 2'd0;
  localparam logic [31:0] WAIT_LIMIT_INIT = 32'd300;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] job_id;
    logic [3:0]  chosen_worker;
    logic [4:0]  position;
  } result_t;

endpackage

// ===== sv/least_loaded_skill_dispatcher.sv =====
// Least-loaded dispatcher with tenant and skill matching.
//
// Input transactions arrive on in_valid/in_stall with one field per port; a
// transaction is taken at a clock edge with in_valid high and in_stall low.
// Results leave on out_valid/out_stall, one transaction per result; out_last
// marks the final result caused by one input. The user must write the wait
// limit (cfg_wr_en/cfg_wr_data) only while idle; the block does not enforce it.
//
// The worker table and the job queue each live in a single-port-write,
// registered-read memory. A request walks the worker table one entry per
// cycle and then decides in ST_DECIDE. A tick reads each queued job in
// ST_QRD and walks the table for it, then finishes in ST_FLUSH. Login and
// logout are done as the transaction is taken; status, take and end
// read-modify-write the entry through ST_RMW. The worker table scan sets
// the rate.
//
// Reset (synchronous, active low) marks every worker absent, empties the
// queue and loads the wait limit with 300. When the receiver stalls, the
// finished result waits in the output register; a request or a tick that
// has a further result waits until that register frees, and no new input
// transaction is accepted until then.
module least_loaded_skill_dispatcher
  import llsd_pkg::*;
#(
  parameter int WORKERS     = 16,
  parameter int QUEUE_DEPTH = 16,
  parameter int SKILL_BITS  = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_action,
  input  logic [3:0]  in_agent_slot,
  input  logic [7:0]  in_tenant,
  input  logic [15:0] in_skill_mask,
  input  logic [3:0]  in_max_load,
  input  logic [1:0]  in_status,
  input  logic [15:0] in_session_id,
  input  logic [31:0] in_time_stamp,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [15:0] out_job_id,
  output logic [3:0]  out_chosen_worker,
  output logic [4:0]  out_position,
  output logic        out_last,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data
);

  // Only the low skill bits that fit both the port and SKILL_BITS matter.
  localparam int SKW  = (SKILL_BITS < 16) ? SKILL_BITS : 16;
  localparam int WIDX = (WORKERS > 1) ? $clog2(WORKERS) : 1;
  localparam int WCW  = $clog2(WORKERS + 1);
  localparam int QIW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCW  = $clog2(QUEUE_DEPTH + 1);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_RMW    = 3'd1;
  localparam logic [2:0] ST_SCAN   = 3'd2;
  localparam logic [2:0] ST_DECIDE = 3'd3;
  localparam logic [2:0] ST_QRD    = 3'd4;
  localparam logic [2:0] ST_FLUSH  = 3'd5;

  typedef struct packed {
    logic [1:0]     status;
    logic [7:0]     tenant;
    logic [SKW-1:0] skills;
    logic [3:0]     capacity;
    logic [3:0]     load;
  } worker_t;

  typedef struct packed {
    logic [15:0]    job;
    logic [7:0]     tenant;
    logic [SKW-1:0] skills;
    logic [31:0]    since;
  } wait_t;

  // Memories: worker table and job queue.
  worker_t wmem [WORKERS];
  wait_t   qmem [QUEUE_DEPTH];

  logic [2:0]       state_r, state_nxt;
  logic [31:0]      wait_limit_r;
  logic [WORKERS-1:0] present_r, present_nxt;
  logic [QCW-1:0]   cnt_r, cnt_nxt;
  logic [QCW-1:0]   qi_r, qi_nxt;
  logic [QCW-1:0]   keep_r, keep_nxt;
  logic [WCW-1:0]   scan_r, scan_nxt;
  logic             eval_v_r;
  logic [WIDX-1:0]  eval_idx_r;
  logic             best_v_r, best_v_nxt;
  logic [WIDX-1:0]  best_idx_r, best_idx_nxt;
  worker_t          best_r, best_nxt;
  logic             hold_v_r, hold_v_nxt;
  result_t          hold_r, hold_nxt;
  logic             out_valid_r;
  result_t          out_r;
  logic             out_last_r;

  // Registered copy of the accepted transaction.
  logic [2:0]       act_r;
  logic [WIDX-1:0]  slot_r;
  logic [1:0]       stat_r;
  logic [15:0]      req_id_r;
  logic [7:0]       req_ten_r;
  logic [SKW-1:0]   req_sk_r;
  logic [31:0]      req_ts_r;

  // Memory ports.
  logic [WIDX-1:0]  w_raddr;
  worker_t          w_rdata_r;
  logic             w_we;
  logic [WIDX-1:0]  w_waddr;
  worker_t          w_wdata;
  logic             q_re;
  wait_t            q_rdata_r;
  logic             q_we;
  logic [QIW-1:0]   q_waddr;
  wait_t            q_wdata;

  logic             in_acc;
  logic             slot_ok;
  logic [WIDX-1:0]  in_slot;
  logic             out_free;
  logic             push_en;
  result_t          push_res;
  logic             push_last;
  logic             is_tick;
  logic [7:0]       job_ten;
  logic [SKW-1:0]   job_sk;
  logic [15:0]      job_id;
  logic             eligible;
  logic             timed_out;
  logic [3:0]       best_load_inc;

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign slot_ok  = (int'(in_agent_slot) < WORKERS);
  assign in_slot  = WIDX'(in_agent_slot);
  assign out_free = !out_valid_r || !out_stall;

  // During a tick the job under test is the queue entry just read.
  assign is_tick = (act_r == ACT_TICK);
  assign job_ten = is_tick ? q_rdata_r.tenant : req_ten_r;
  assign job_sk  = is_tick ? q_rdata_r.skills : req_sk_r;
  assign job_id  = is_tick ? q_rdata_r.job : req_id_r;

  assign eligible = present_r[eval_idx_r] && (w_rdata_r.status == STATUS_ONLINE) &&
                    (w_rdata_r.load < w_rdata_r.capacity) &&
                    (w_rdata_r.tenant == job_ten) &&
                    ((job_sk & ~w_rdata_r.skills) == '0);

  assign timed_out     = (req_ts_r - q_rdata_r.since) > wait_limit_r;
  assign best_load_inc = (best_r.load < LOAD_MAX) ? best_r.load + 4'd1 : best_r.load;

  always_comb begin
    state_nxt    = state_r;
    present_nxt  = present_r;
    cnt_nxt      = cnt_r;
    qi_nxt       = qi_r;
    keep_nxt     = keep_r;
    scan_nxt     = scan_r;
    best_v_nxt   = best_v_r;
    best_idx_nxt = best_idx_r;
    best_nxt     = best_r;
    hold_v_nxt   = hold_v_r;
    hold_nxt     = hold_r;
    w_raddr      = WIDX'(scan_r);
    w_we         = 1'b0;
    w_waddr      = best_idx_r;
    w_wdata      = best_r;
    q_re         = 1'b0;
    q_we         = 1'b0;
    q_waddr      = keep_r[QIW-1:0];
    q_wdata      = q_rdata_r;
    push_en      = 1'b0;
    push_res     = hold_r;
    push_last    = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        w_raddr = in_slot;
        if (in_acc) begin
          case (in_action)
            ACT_LOGIN: begin
              if (slot_ok) begin
                present_nxt[in_slot] = 1'b1;
                w_we    = 1'b1;
                w_waddr = in_slot;
                w_wdata = '{status: in_status, tenant: in_tenant,
                            skills: in_skill_mask[SKW-1:0], capacity: in_max_load,
                            load: 4'd0};
              end
            end
            ACT_LOGOUT: begin
              if (slot_ok) present_nxt[in_slot] = 1'b0;
            end
            ACT_STATUS, ACT_TAKE, ACT_END: begin
              if (slot_ok && present_r[in_slot]) state_nxt = ST_RMW;
            end
            ACT_REQUEST: begin
              scan_nxt   = '0;
              best_v_nxt = 1'b0;
              state_nxt  = ST_SCAN;
            end
            ACT_TICK: begin
              qi_nxt   = '0;
              keep_nxt = '0;
              if (cnt_r != '0) state_nxt = ST_QRD;
            end
            default: ;
          endcase
        end
      end

      ST_RMW: begin
        w_we    = 1'b1;
        w_waddr = slot_r;
        w_wdata = w_rdata_r;
        case (act_r)
          ACT_STATUS: w_wdata.status = stat_r;
          ACT_TAKE: begin
            if (w_rdata_r.load < LOAD_MAX) w_wdata.load = w_rdata_r.load + 4'd1;
          end
          default: begin
            if (w_rdata_r.load != 4'd0) w_wdata.load = w_rdata_r.load - 4'd1;
          end
        endcase
        state_nxt = ST_IDLE;
      end

      ST_QRD: begin
        q_re       = 1'b1;
        scan_nxt   = '0;
        best_v_nxt = 1'b0;
        state_nxt  = ST_SCAN;
      end

      ST_SCAN: begin
        if (int'(scan_r) < WORKERS) scan_nxt = scan_r + WCW'(1);
        if (eval_v_r && eligible && (!best_v_r || w_rdata_r.load < best_r.load)) begin
          best_v_nxt   = 1'b1;
          best_idx_nxt = eval_idx_r;
          best_nxt     = w_rdata_r;
        end
        if (eval_v_r && (int'(eval_idx_r) == WORKERS - 1)) state_nxt = ST_DECIDE;
      end

      ST_DECIDE: begin
        w_wdata.load = best_load_inc;
        if (!is_tick) begin
          // A request always yields exactly one result.
          if (out_free) begin
            push_en   = 1'b1;
            push_last = 1'b1;
            push_res  = '{kind: KIND_ASSIGNED, job_id: req_id_r,
                          chosen_worker: 4'(best_idx_r), position: 5'd0};
            if (best_v_r) begin
              w_we = 1'b1;
            end else if (int'(cnt_r) < QUEUE_DEPTH) begin
              q_we    = 1'b1;
              q_waddr = cnt_r[QIW-1:0];
              q_wdata = '{job: req_id_r, tenant: req_ten_r, skills: req_sk_r,
                          since: req_ts_r};
              cnt_nxt = cnt_r + QCW'(1);
              push_res.kind          = KIND_QUEUED;
              push_res.chosen_worker = 4'd0;
              push_res.position      = 5'(cnt_r + QCW'(1));
            end else begin
              push_res.kind          = KIND_DROPPED;
              push_res.chosen_worker = 4'd0;
            end
            state_nxt = ST_IDLE;
          end
        end else if (!((best_v_r || timed_out) && hold_v_r) || out_free) begin
          // The previous tick result can only go out once we know it is not last.
          if (best_v_r || timed_out) begin
            push_en    = hold_v_r;
            hold_v_nxt = 1'b1;
            hold_nxt   = '{kind: KIND_ASSIGNED, job_id: job_id,
                           chosen_worker: 4'(best_idx_r), position: 5'd0};
            if (best_v_r) begin
              w_we = 1'b1;
            end else begin
              hold_nxt.kind          = KIND_TIMEOUT;
              hold_nxt.chosen_worker = 4'd0;
            end
          end else begin
            q_we     = 1'b1;
            keep_nxt = keep_r + QCW'(1);
          end
          qi_nxt    = qi_r + QCW'(1);
          state_nxt = (qi_r + QCW'(1) == cnt_r) ? ST_FLUSH : ST_QRD;
        end
      end

      ST_FLUSH: begin
        if (!hold_v_r || out_free) begin
          push_en    = hold_v_r;
          push_last  = 1'b1;
          hold_v_nxt = 1'b0;
          cnt_nxt    = keep_r;
          state_nxt  = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // Worker table memory.
  always_ff @(posedge clk) begin
    if (w_we) wmem[w_waddr] <= w_wdata;
    w_rdata_r <= wmem[w_raddr];
  end

  // Job queue memory.
  always_ff @(posedge clk) begin
    if (q_we) qmem[q_waddr] <= q_wdata;
    if (q_re) q_rdata_r <= qmem[qi_r[QIW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      wait_limit_r <= WAIT_LIMIT_INIT;
      present_r    <= '0;
      cnt_r        <= '0;
      hold_v_r     <= 1'b0;
      out_valid_r  <= 1'b0;
      eval_v_r     <= 1'b0;
      best_v_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      present_r <= present_nxt;
      cnt_r    <= cnt_nxt;
      hold_v_r <= hold_v_nxt;
      best_v_r <= best_v_nxt;
      eval_v_r <= (state_r == ST_SCAN) && (int'(scan_r) < WORKERS);
      if (cfg_wr_en) wait_limit_r <= cfg_wr_data;
      if (push_en) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    qi_r       <= qi_nxt;
    keep_r     <= keep_nxt;
    scan_r     <= scan_nxt;
    eval_idx_r <= WIDX'(scan_r);
    best_idx_r <= best_idx_nxt;
    best_r     <= best_nxt;
    hold_r     <= hold_nxt;
    if (push_en) begin
      out_r      <= push_res;
      out_last_r <= push_last;
    end
    if (in_acc) begin
      act_r     <= in_action;
      slot_r    <= in_slot;
      stat_r    <= in_status;
      req_id_r  <= in_session_id;
      req_ten_r <= in_tenant;
      req_sk_r  <= in_skill_mask[SKW-1:0];
      req_ts_r  <= in_time_stamp;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_kind          = out_r.kind;
  assign out_job_id        = out_r.job_id;
  assign out_chosen_worker = out_r.chosen_worker;
  assign out_position      = out_r.position;
  assign out_last          = out_last_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(cnt_r) <= QUEUE_DEPTH) else $error("queue count above depth");

  a_keep_le_qi: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DECIDE && is_tick) |-> keep_r <= qi_r)
    else $error("queue compaction overtook the read pointer");

  a_hold_tick: assert property (@(posedge clk) disable iff (!rst_n)
    hold_v_r |-> (state_r != ST_IDLE && is_tick))
    else $error("held result outside a tick");

  a_queued_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.kind == KIND_QUEUED) |-> (out_r.position != 5'd0 && out_last_r))
    else $error("queued result without a position");

endmodule
